// ----- hdl/bdpd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the button debounce and press detector.
// No dependencies.
package bdpd_pkg;

   localparam int NUM_BUTTONS_DEF = 5;
   localparam int BUTTON_W        = 3;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_PRESS_MIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_PRESS_TICKS = 2'd2;

   localparam logic [3:0] DEBOUNCE_COUNT_RST   = 4'd3;
   localparam logic [7:0] SHORT_PRESS_MIN_RST  = 8'd2;
   localparam logic [7:0] LONG_PRESS_TICKS_RST = 8'd100;

   localparam logic [7:0] COUNTER_MAX = 8'd255;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   typedef struct packed {
      logic [3:0] debounce_count;
      logic [7:0] short_press_min;
      logic [7:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic       level_after;
      logic [1:0] event_code;
   } lane_status_type;

   typedef enum logic [2:0] {
      PHASE_IDLE    = 3'b001,
      PHASE_PRESSED = 3'b010,
      PHASE_LONG    = 3'b100
   } phase_type;

endpackage

// ----- hdl/bdpd_lane.sv -----
`timescale 1ns / 1ps
// One button qualifier: integrating counter, debounced level, press phase, event latch.
// Depends on bdpd_pkg.
module bdpd_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  bdpd_pkg::cfg_type         cfg,
   input  logic                      tick,
   input  logic                      clear,
   input  logic                      pressed,
   output bdpd_pkg::lane_status_type status
);

   logic [7:0]          cnt_ff, cnt_in;
   logic                level_ff, level_in;
   bdpd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          event_ff, event_in;
   logic [3:0]          thr;
   logic [7:0]          thr8;

   always_comb begin
      thr      = (cfg.debounce_count == 4'd0) ? 4'd1 : cfg.debounce_count;
      thr8     = {4'd0, thr};
      cnt_in   = cnt_ff;
      level_in = level_ff;
      phase_in = phase_ff;
      event_in = event_ff;
      if (tick) begin
         if (pressed) begin
            if (cnt_ff != bdpd_pkg::COUNTER_MAX) cnt_in = cnt_ff + 8'd1;
         end else if (cnt_ff != 8'd0) begin
            cnt_in = (cnt_ff >= thr8) ? (thr8 - 8'd1) : (cnt_ff - 8'd1);
         end
         level_in = (cnt_in >= thr8);
         if (level_ff && !level_in) begin
            if (phase_ff == bdpd_pkg::PHASE_PRESSED && cnt_ff > cfg.short_press_min)
               event_in = bdpd_pkg::EV_SHORT;
            phase_in = bdpd_pkg::PHASE_IDLE;
         end else if (!level_ff && level_in) begin
            phase_in = bdpd_pkg::PHASE_PRESSED;
         end else if (level_ff && level_in) begin
            if (cnt_in > cfg.long_press_ticks && phase_ff == bdpd_pkg::PHASE_PRESSED) begin
               phase_in = bdpd_pkg::PHASE_LONG;
               event_in = bdpd_pkg::EV_LONG;
            end
         end
      end else if (clear) begin
         event_in = bdpd_pkg::EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 8'd0;
         level_ff <= 1'b0;
         phase_ff <= bdpd_pkg::PHASE_IDLE;
         event_ff <= bdpd_pkg::EV_NONE;
      end else begin
         cnt_ff   <= cnt_in;
         level_ff <= level_in;
         phase_ff <= phase_in;
         event_ff <= event_in;
      end
   end

   assign status.level_after = level_in;
   assign status.event_code  = event_ff;

endmodule

// ----- hdl/bdpd_merge.sv -----
`timescale 1ns / 1ps
// Merges lane status into one result item and holds it in the output register.
// Depends on bdpd_pkg.
module bdpd_merge #(
   parameter int NUM_BUTTONS = bdpd_pkg::NUM_BUTTONS_DEF,
   parameter int RSP_W       = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          action,
   input  logic [bdpd_pkg::BUTTON_W-1:0] button,
   input  bdpd_pkg::lane_status_type     status [NUM_BUTTONS],
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,
   output logic                          out_free
);

   logic                   valid_ff, valid_in;
   logic [RSP_W-1:0]       data_ff, data_in;
   logic [NUM_BUTTONS-1:0] mask;
   logic [1:0]             code;

   always_comb begin
      code = bdpd_pkg::EV_NONE;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         mask[i] = status[i].level_after;
         if (action == bdpd_pkg::ACTION_READ && button == i[bdpd_pkg::BUTTON_W-1:0])
            code = status[i].event_code;
      end
      data_in = RSP_W'({code, mask});
   end

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = accept || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ----- hdl/button_debounce_press_detector_core.sv -----
`timescale 1ns / 1ps
// Bank of button qualifiers with short and long press detection.
// Depends on bdpd_pkg, bdpd_lane, bdpd_merge.
//
// Each accepted item's result reaches the output register on the next cycle; items can
// follow back to back, one per clock unless stalled. The only stall is the output
// register: req_tready drops while a result waits and rsp_tready is low. A tick item
// (tuser 0) updates every lane in parallel; a read item (tuser 1) returns and clears one
// button's latched event. Write registers through csr_ only while idle (not enforced).
module button_debounce_press_detector_core #(
   parameter int NUM_BUTTONS = bdpd_pkg::NUM_BUTTONS_DEF,
   localparam int REQ_W = ((NUM_BUTTONS + bdpd_pkg::BUTTON_W + 7) / 8) * 8,
   localparam int RSP_W = ((NUM_BUTTONS + 2 + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [REQ_W-1:0]                 req_tdata,  // raw_levels, button
   input  logic                             req_tuser,  // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [RSP_W-1:0]                 rsp_tdata,  // debounced_mask, event_code
   input  logic                             csr_we,
   input  logic [bdpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bdpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bdpd_pkg::cfg_type                 cfg_ff;
   bdpd_pkg::lane_status_type         status [NUM_BUTTONS];
   logic                              accept;
   logic                              out_free;
   logic [NUM_BUTTONS-1:0]            raw_levels;
   logic [bdpd_pkg::BUTTON_W-1:0]     button;

   assign raw_levels = req_tdata[NUM_BUTTONS-1:0];
   assign button     = req_tdata[NUM_BUTTONS +: bdpd_pkg::BUTTON_W];
   assign req_tready = out_free;
   assign accept     = req_tvalid && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count   <= bdpd_pkg::DEBOUNCE_COUNT_RST;
         cfg_ff.short_press_min  <= bdpd_pkg::SHORT_PRESS_MIN_RST;
         cfg_ff.long_press_ticks <= bdpd_pkg::LONG_PRESS_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            bdpd_pkg::REG_DEBOUNCE_COUNT:   cfg_ff.debounce_count   <= csr_wdata[3:0];
            bdpd_pkg::REG_SHORT_PRESS_MIN:  cfg_ff.short_press_min  <= csr_wdata;
            bdpd_pkg::REG_LONG_PRESS_TICKS: cfg_ff.long_press_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      bdpd_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg_ff),
         .tick    (accept && req_tuser == bdpd_pkg::ACTION_TICK),
         .clear   (accept && req_tuser == bdpd_pkg::ACTION_READ &&
                   button == bdpd_pkg::BUTTON_W'(g)),
         .pressed (!raw_levels[g]),
         .status  (status[g])
      );
   end

   bdpd_merge #(
      .NUM_BUTTONS (NUM_BUTTONS),
      .RSP_W       (RSP_W)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_tuser),
      .button     (button),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .out_free   (out_free)
   );

endmodule

// ----- hdl/bdpd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the button debounce and press detector, bound to the top level.
// Depends on bdpd_pkg and button_debounce_press_detector_core.
module bdpd_checker #(
   parameter int NUM_BUTTONS = bdpd_pkg::NUM_BUTTONS_DEF,
   localparam int REQ_W = ((NUM_BUTTONS + bdpd_pkg::BUTTON_W + 7) / 8) * 8,
   localparam int RSP_W = ((NUM_BUTTONS + 2 + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic                          req_acc;
   logic [bdpd_pkg::BUTTON_W-1:0] btn;
   logic [1:0]                    rsp_code;

   assign req_acc  = req_tvalid && req_tready;
   assign btn      = req_tdata[NUM_BUTTONS +: bdpd_pkg::BUTTON_W];
   assign rsp_code = rsp_tdata[NUM_BUTTONS +: 2];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_tick_no_event: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser == bdpd_pkg::ACTION_TICK |=>
         rsp_tvalid && rsp_code == bdpd_pkg::EV_NONE)
      else $error("tick item returned an event");

   a_bad_button: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tuser == bdpd_pkg::ACTION_READ &&
      {29'd0, btn} >= NUM_BUTTONS |=> rsp_code == bdpd_pkg::EV_NONE)
      else $error("read of missing button returned an event");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == bdpd_pkg::ACTION_READ) ##1
      (req_acc && req_tuser == bdpd_pkg::ACTION_READ && btn == $past(btn)) |=>
         rsp_code == bdpd_pkg::EV_NONE)
      else $error("event not cleared by read");

endmodule

bind button_debounce_press_detector_core bdpd_checker #(
   .NUM_BUTTONS (NUM_BUTTONS)
) u_bdpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/button_debounce_press_detector_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for button_debounce_press_detector_core: a queue-fed driver,
// a checking monitor and a per-item predictor of the button lanes.
// Depends on bdpd_pkg and the core RTL.
module button_debounce_press_detector_core_tb;

   localparam int NUM_BUTTONS = bdpd_pkg::NUM_BUTTONS_DEF;
   localparam int REQ_W       = ((NUM_BUTTONS + bdpd_pkg::BUTTON_W + 7) / 8) * 8;
   localparam int RSP_W       = ((NUM_BUTTONS + 2 + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int MAX_REPORTS = 50;

   typedef struct packed {
      logic       action;
      logic [4:0] raw;
      logic [2:0] btn;
   } press_req_type;

   typedef struct packed {
      logic [1:0] event_code;
      logic [4:0] mask;
   } button_status_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // raw_levels, button
   logic             req_tuser = 1'b0; // action
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // debounced_mask, event_code
   logic                             csr_we = 1'b0;
   logic [bdpd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bdpd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   press_req_type     item_q[$];
   button_status_type status_q[$];
   press_req_type     drv_item;
   logic              req_taken = 1'b0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                queued_count = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bdpd_pkg::cfg_type stim_cfg;

   // predictor state
   bdpd_pkg::cfg_type   model_cfg;
   logic [7:0]          press_cnt [NUM_BUTTONS];
   logic                level_st  [NUM_BUTTONS];
   bdpd_pkg::phase_type phase_st  [NUM_BUTTONS];
   logic [1:0]          latched   [NUM_BUTTONS];

   button_debounce_press_detector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic button_status_type advance_buttons(logic action, logic [4:0] raw,
                                                         logic [2:0] btn);
      logic [7:0]        thr;
      logic [7:0]        old_cnt;
      logic [7:0]        c;
      logic              nl;
      button_status_type r;
      r.event_code = bdpd_pkg::EV_NONE;
      if (action == bdpd_pkg::ACTION_TICK) begin
         thr = (model_cfg.debounce_count == 0) ? 8'd1 : {4'd0, model_cfg.debounce_count};
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            old_cnt = press_cnt[i];
            c = old_cnt;
            if (!raw[i]) begin
               if (c != bdpd_pkg::COUNTER_MAX) c = c + 8'd1;
            end else if (c != 0) begin
               if (c >= thr) c = thr - 8'd1;
               else c = c - 8'd1;
            end
            nl = (c >= thr);
            if (level_st[i] && !nl) begin
               if (phase_st[i] == bdpd_pkg::PHASE_PRESSED &&
                   old_cnt > model_cfg.short_press_min)
                  latched[i] = bdpd_pkg::EV_SHORT;
               phase_st[i] = bdpd_pkg::PHASE_IDLE;
            end else if (!level_st[i] && nl) begin
               phase_st[i] = bdpd_pkg::PHASE_PRESSED;
            end else if (level_st[i] && nl) begin
               if (c > model_cfg.long_press_ticks &&
                   phase_st[i] == bdpd_pkg::PHASE_PRESSED) begin
                  phase_st[i] = bdpd_pkg::PHASE_LONG;
                  latched[i] = bdpd_pkg::EV_LONG;
               end
            end
            press_cnt[i] = c;
            level_st[i] = nl;
         end
      end else if (btn < NUM_BUTTONS) begin
         r.event_code = latched[btn];
         latched[btn] = bdpd_pkg::EV_NONE;
      end
      for (int i = 0; i < NUM_BUTTONS; i++) r.mask[i] = level_st[i];
      return r;
   endfunction

   // monitor: accepts, predicts and checks on the rising edge
   always @(posedge clock) begin
      button_status_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[button_debounce_press_detector_core] ERROR");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
         model_cfg.debounce_count   = bdpd_pkg::DEBOUNCE_COUNT_RST;
         model_cfg.short_press_min  = bdpd_pkg::SHORT_PRESS_MIN_RST;
         model_cfg.long_press_ticks = bdpd_pkg::LONG_PRESS_TICKS_RST;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            press_cnt[i] = '0;
            level_st[i]  = 1'b0;
            phase_st[i]  = bdpd_pkg::PHASE_IDLE;
            latched[i]   = bdpd_pkg::EV_NONE;
         end
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_we) begin
            case (csr_index)
               bdpd_pkg::REG_DEBOUNCE_COUNT:
                  model_cfg.debounce_count = csr_wdata[3:0];
               bdpd_pkg::REG_SHORT_PRESS_MIN:
                  model_cfg.short_press_min = csr_wdata;
               bdpd_pkg::REG_LONG_PRESS_TICKS:
                  model_cfg.long_press_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected item, expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = status_q.pop_front();
               if (rsp_tdata[4:0] !== want.mask) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: debounced_mask expected %h actual %h",
                              $time, want.mask, rsp_tdata[4:0]);
               end
               if (rsp_tdata[6:5] !== want.event_code) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: event_code expected %0d actual %0d",
                              $time, want.event_code, rsp_tdata[6:5]);
               end
            end
         end
         if (req_tvalid && req_tready)
            status_q.push_back(advance_buttons(req_tuser, req_tdata[4:0], req_tdata[7:5]));
      end
   end

   // driver: changes inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               drv_item = item_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {drv_item.btn, drv_item.raw};
               req_tuser  <= drv_item.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic queue_item(logic action, logic [4:0] raw, logic [2:0] btn);
      press_req_type it;
      it.action = action;
      it.raw = raw;
      it.btn = btn;
      item_q.push_back(it);
      queued_count++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (item_q.size() != 0 || req_tvalid || status_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(logic [3:0] db, logic [7:0] smin, logic [7:0] lng);
      stim_cfg.debounce_count = db;
      stim_cfg.short_press_min = smin;
      stim_cfg.long_press_ticks = lng;
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= bdpd_pkg::REG_DEBOUNCE_COUNT;
      csr_wdata <= {4'd0, db};
      @(negedge clock);
      csr_index <= bdpd_pkg::REG_SHORT_PRESS_MIN;
      csr_wdata <= smin;
      @(negedge clock);
      csr_index <= bdpd_pkg::REG_LONG_PRESS_TICKS;
      csr_wdata <= lng;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // press and hold a set of buttons, release them, then read the events of some of them
   task automatic queue_press_burst();
      logic [4:0] held;
      logic [4:0] raw;
      int         thr;
      int         hold_len;
      int         rel_len;
      int         sel;
      held = 5'($urandom_range(1, 31));
      thr = (stim_cfg.debounce_count == 0) ? 1 : stim_cfg.debounce_count;
      sel = $urandom_range(0, 9);
      if (sel < 6) hold_len = $urandom_range(1, thr + 3);
      else if (sel < 8) hold_len = stim_cfg.short_press_min + $urandom_range(0, 2);
      else hold_len = stim_cfg.long_press_ticks + $urandom_range(0, 2);
      if (hold_len < 1) hold_len = 1;
      for (int t = 0; t < hold_len; t++) begin
         raw = ~held;
         if ($urandom_range(0, 15) == 0) raw = raw ^ (5'd1 << $urandom_range(0, 4));
         queue_item(bdpd_pkg::ACTION_TICK, raw, 3'($urandom_range(0, 7)));
         if ($urandom_range(0, 19) == 0)
            queue_item(bdpd_pkg::ACTION_READ, 5'($urandom_range(0, 31)),
                       3'($urandom_range(0, 7)));
      end
      rel_len = $urandom_range(1, thr + 2);
      for (int t = 0; t < rel_len; t++) begin
         raw = 5'h1f;
         if ($urandom_range(0, 11) == 0) raw = raw ^ (5'd1 << $urandom_range(0, 4));
         queue_item(bdpd_pkg::ACTION_TICK, raw, 3'($urandom_range(0, 7)));
      end
      for (int b = 0; b < NUM_BUTTONS; b++)
         if (held[b] && $urandom_range(0, 9) < 7)
            queue_item(bdpd_pkg::ACTION_READ, 5'($urandom_range(0, 31)), 3'(b));
      if ($urandom_range(0, 3) == 0)
         queue_item(bdpd_pkg::ACTION_READ, 5'($urandom_range(0, 31)),
                    3'($urandom_range(0, 7)));
   endtask

   initial begin
      logic [3:0] plan_db   [5] = '{4'd1, 4'd15, 4'd0, 4'd7, 4'd2};
      logic [7:0] plan_smin [5] = '{8'd0, 8'd255, 8'd20, 8'd9, 8'd5};
      logic [7:0] plan_long [5] = '{8'd1, 8'd254, 8'd255, 8'd40, 8'd12};
      int         plan_send [5] = '{87, 0, 21, 0, 87};
      int         plan_stall[5] = '{0, 87, 21, 0, 87};
      int         plan_items[5] = '{150, 350, 150, 250, 200};
      int         phase_end;
      stim_cfg.debounce_count = bdpd_pkg::DEBOUNCE_COUNT_RST;
      stim_cfg.short_press_min = bdpd_pkg::SHORT_PRESS_MIN_RST;
      stim_cfg.long_press_ticks = bdpd_pkg::LONG_PRESS_TICKS_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings, no idling: reads before any press, out-of-range buttons,
      // ignored fields, short presses on every button but button 3
      queue_item(bdpd_pkg::ACTION_READ, 5'h00, 3'd0);
      queue_item(bdpd_pkg::ACTION_READ, 5'h1f, 3'd7);
      queue_item(bdpd_pkg::ACTION_READ, 5'h00, 3'd5);
      repeat (4) queue_item(bdpd_pkg::ACTION_TICK, 5'b11110, 3'd7);
      queue_item(bdpd_pkg::ACTION_TICK, 5'b00000, 3'd0);
      queue_item(bdpd_pkg::ACTION_TICK, 5'b01000, 3'd6);
      queue_item(bdpd_pkg::ACTION_TICK, 5'b00000, 3'd3);
      queue_item(bdpd_pkg::ACTION_TICK, 5'b00000, 3'd4);
      repeat (3) queue_item(bdpd_pkg::ACTION_TICK, 5'b11111, 3'd2);
      for (int b = 0; b < NUM_BUTTONS; b++) queue_item(bdpd_pkg::ACTION_READ, 5'h15, 3'(b));
      queue_item(bdpd_pkg::ACTION_READ, 5'h0a, 3'd0);
      queue_item(bdpd_pkg::ACTION_READ, 5'h1f, 3'd6);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         write_config(plan_db[p], plan_smin[p], plan_long[p]);
         send_idle_pct = plan_send[p];
         stall_pct = plan_stall[p];
         phase_end = queued_count + plan_items[p];
         while (queued_count < phase_end) begin
            if ($urandom_range(0, 6) == 0)
               queue_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                          3'($urandom_range(0, 7)));
            else
               queue_press_burst();
         end
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && status_q.size() == 0) begin
         $display("[button_debounce_press_detector_core] OK");
      end else begin
         $display("[button_debounce_press_detector_core] ERROR");
      end
      $finish;
   end

endmodule
